// ----- sv/e8bm_pkg.sv -----
// Shared types and constants for the e8 block map and checked inverse.
// Used by every module of the block; no dependencies.
package e8bm_pkg;

   // Fixed geometry of one block word
   localparam int NUM_ELEMS     = 8;
   localparam int VEC_W         = 23;
   localparam int NORM_W        = 46;
   localparam int COSET_W       = 4;
   localparam int TAU_W         = 8;
   localparam int ELEM_BITS_DEF = 19;

   // Operation selected by req_action
   typedef enum logic {
      ACT_FORWARD = 1'b0,
      ACT_INVERSE = 1'b1
   } action_type;

   // Bounds of the 32-bit signed quotient range
   localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
   localparam logic signed [63:0] Q_MAX = 64'sd2147483647;

   // Numerator matrix of the inverse (result is this times x, over 4)
   localparam logic signed [3:0] INV_NUM [NUM_ELEMS][NUM_ELEMS] = '{
      '{ 4'sd1,  4'sd1, -4'sd1,  4'sd1,  4'sd1, -4'sd3,  4'sd3, -4'sd1},
      '{-4'sd1,  4'sd1,  4'sd1, -4'sd1,  4'sd1,  4'sd1, -4'sd3,  4'sd3},
      '{ 4'sd1, -4'sd1,  4'sd1,  4'sd1, -4'sd3,  4'sd1,  4'sd1, -4'sd3},
      '{-4'sd1,  4'sd1, -4'sd1,  4'sd1,  4'sd3, -4'sd3,  4'sd1,  4'sd1},
      '{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd2,  4'sd0,  4'sd0,  4'sd2},
      '{ 4'sd0,  4'sd0,  4'sd0,  4'sd0, -4'sd2,  4'sd2,  4'sd0,  4'sd0},
      '{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0, -4'sd2,  4'sd2,  4'sd0},
      '{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0, -4'sd2,  4'sd2}
   };

   // Parity check rows of the first-order Reed-Muller code of length 8
   localparam logic [7:0] CHECK_ROWS [COSET_W] = '{8'hFF, 8'hAA, 8'hCC, 8'hF0};

   // Outcome of the inverse checks
   typedef struct packed {
      logic                ok;
      logic [COSET_W-1:0]  syndrome;
   } check_type;

endpackage

// ----- sv/e8bm_fwd_map.sv -----
// Forward map P on one block: negacyclic shifts of the two halves, summed.
// Purely combinational; depends on e8bm_pkg.
module e8bm_fwd_map #(
   parameter int IN_W = e8bm_pkg::ELEM_BITS_DEF
) (
   input  logic signed [IN_W-1:0]   z [e8bm_pkg::NUM_ELEMS],
   output logic signed [IN_W+3:0]   x [e8bm_pkg::NUM_ELEMS]
);

   localparam int OUT_W = IN_W + 4;

   logic signed [OUT_W-1:0] ze [e8bm_pkg::NUM_ELEMS];
   logic signed [OUT_W-1:0] a1;
   logic signed [OUT_W-1:0] b1;
   logic signed [OUT_W-1:0] b2;
   logic signed [OUT_W-1:0] b3;

   // Element u of a shift by s takes h[u-s], negated when it wraps around
   always_comb begin
      for (int k = 0; k < e8bm_pkg::NUM_ELEMS; k++) begin
         ze[k] = OUT_W'(z[k]);
      end
      for (int u = 0; u < 4; u++) begin
         a1 = ze[{1'b0, 2'(u + 3)}];
         b1 = ze[{1'b1, 2'(u + 3)}];
         b2 = ze[{1'b1, 2'(u + 2)}];
         b3 = ze[{1'b1, 2'(u + 1)}];
         if (u < 1) begin
            a1 = -a1;
            b1 = -b1;
         end
         if (u < 2) begin
            b2 = -b2;
         end
         if (u < 3) begin
            b3 = -b3;
         end
         x[3'(u)]     = ((ze[3'(u)] + a1) <<< 1) + ze[3'(u + 4)] - b1 + b2 + b3;
         x[3'(u + 4)] = ze[3'(u + 4)] + b1 + b2 + b3;
      end
   end

endmodule

// ----- sv/e8bm_inv_solve.sv -----
// Inverse numerators and quotients: num = Q * x, z = num / 4, with divisibility flag.
// Purely combinational; depends on e8bm_pkg.
module e8bm_inv_solve #(
   parameter int ELEM_BITS = e8bm_pkg::ELEM_BITS_DEF
) (
   input  logic signed [ELEM_BITS-1:0] v [e8bm_pkg::NUM_ELEMS],
   output logic signed [ELEM_BITS+1:0] q [e8bm_pkg::NUM_ELEMS],
   output logic                        div_ok
);

   // Row sums of |Q| are at most 12, so four extra bits hold any numerator
   localparam int NUM_W = ELEM_BITS + 4;

   logic signed [NUM_W-1:0] acc;

   always_comb begin
      div_ok = 1'b1;
      for (int i = 0; i < e8bm_pkg::NUM_ELEMS; i++) begin
         acc = '0;
         for (int j = 0; j < e8bm_pkg::NUM_ELEMS; j++) begin
            acc = acc + NUM_W'(v[j]) * NUM_W'(e8bm_pkg::INV_NUM[i][j]);
         end
         // exact quotient whenever the two low bits are clear
         div_ok = div_ok & (acc[1:0] == 2'b00);
         q[i]   = acc[NUM_W-1:2];
      end
   end

endmodule

// ----- sv/e8bm_check.sv -----
// Checks on the inverse quotients: range, parity against tau, P(z) == x;
// also forms the coset syndrome of the lift parity. Depends on e8bm_pkg, e8bm_fwd_map.
module e8bm_check #(
   parameter int ELEM_BITS = e8bm_pkg::ELEM_BITS_DEF
) (
   input  logic signed [ELEM_BITS+1:0]       q [e8bm_pkg::NUM_ELEMS],
   input  logic signed [ELEM_BITS-1:0]       v [e8bm_pkg::NUM_ELEMS],
   input  logic [e8bm_pkg::TAU_W-1:0]        tau,
   input  logic                              div_ok,
   output e8bm_pkg::check_type               status
);

   localparam int Q_W   = ELEM_BITS + 2;
   localparam int CHK_W = Q_W + 4;

   logic signed [CHK_W-1:0] chk [e8bm_pkg::NUM_ELEMS];
   logic signed [63:0]      q_wide;
   logic [7:0]              lift;
   logic                    ok;

   // Map the quotients forward again for the recheck
   e8bm_fwd_map #(
      .IN_W (Q_W)
   ) u_recheck (
      .z (q),
      .x (chk)
   );

   always_comb begin
      ok = div_ok;
      for (int i = 0; i < e8bm_pkg::NUM_ELEMS; i++) begin
         q_wide = 64'(q[i]);
         if ((q_wide < e8bm_pkg::Q_MIN) || (q_wide > e8bm_pkg::Q_MAX)) begin
            ok = 1'b0;
         end
         if (q[i][0] != tau[i]) begin
            ok = 1'b0;
         end
         if (chk[i] != CHK_W'(v[i])) begin
            ok = 1'b0;
         end
         // bit 0 equals tau here, so (z - tau)/2 has z bit 1 as its low bit
         lift[i] = q[i][1];
      end
      status.ok = ok;
      for (int r = 0; r < e8bm_pkg::COSET_W; r++) begin
         status.syndrome[r] = ^(lift & e8bm_pkg::CHECK_ROWS[r]);
      end
   end

endmodule

// ----- sv/e8bm_norm.sv -----
// Squared norm of one block: registered squares, then a summing tree (mod 2^46).
// Depends on e8bm_pkg.
module e8bm_norm #(
   parameter int XW = e8bm_pkg::ELEM_BITS_DEF + 4
) (
   input  logic                              clock,
   input  logic signed [XW-1:0]              src [e8bm_pkg::NUM_ELEMS],
   output logic [e8bm_pkg::NORM_W-1:0]       sum
);

   localparam int PW = 2 * XW;

   logic signed [PW-1:0]               prod   [e8bm_pkg::NUM_ELEMS];
   logic [e8bm_pkg::NORM_W-1:0]        sq_in  [e8bm_pkg::NUM_ELEMS];
   logic [e8bm_pkg::NORM_W-1:0]        sq_ff  [e8bm_pkg::NUM_ELEMS];
   logic [e8bm_pkg::NORM_W-1:0]        pair   [4];
   logic [e8bm_pkg::NORM_W-1:0]        quad   [2];

   // One square per element; only the low norm bits are kept
   always_comb begin
      for (int k = 0; k < e8bm_pkg::NUM_ELEMS; k++) begin
         prod[k]  = PW'(src[k]) * PW'(src[k]);
         sq_in[k] = e8bm_pkg::NORM_W'(prod[k]);
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   // Three-level adder tree
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pair[k] = sq_ff[3'(2 * k)] + sq_ff[3'(2 * k + 1)];
      end
      quad[0] = pair[0] + pair[1];
      quad[1] = pair[2] + pair[3];
      sum     = quad[0] + quad[1];
   end

endmodule

// ----- sv/e8_block_map_and_checked_inverse_top.sv -----
// Top level of the e8 block map and checked inverse.
// Depends on e8bm_pkg, e8bm_fwd_map, e8bm_inv_solve, e8bm_check, e8bm_norm.
//
// Usage:
//   Drive req_action, req_tau and req_vec_in_0..7 and raise start; the word is
//   taken at the rising edge where start is high and busy is low. busy is only
//   high during reset, so a new word can be taken in every cycle.
//   req_action selects the forward map (x = P z, with its squared norm) or
//   the checked inverse (z = Q x / 4, with divisibility, parity and recheck).
//   Each result word appears on the rsp_ ports for exactly one cycle with
//   rsp_strobe high. The receiver cannot stall the block: it must take the word
//   in that cycle.
//   Each word passes through four register stages (input, map/solve,
//   check/square, result); rsp_strobe is driven from the result stage.
//   Throughput: one word per cycle, set by the pipeline having no shared unit.
//   A failed inverse returns all fields zero, including rsp_valid_flag.
//   Reset (synchronous, active high) clears the stage valid bits, so no stray
//   strobe follows reset; words in flight are dropped.
module e8_block_map_and_checked_inverse_top #(
   parameter int ELEM_BITS = e8bm_pkg::ELEM_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [e8bm_pkg::TAU_W-1:0]         req_tau,
   input  logic signed [ELEM_BITS-1:0]        req_vec_in_0,
   input  logic signed [ELEM_BITS-1:0]        req_vec_in_1,
   input  logic signed [ELEM_BITS-1:0]        req_vec_in_2,
   input  logic signed [ELEM_BITS-1:0]        req_vec_in_3,
   input  logic signed [ELEM_BITS-1:0]        req_vec_in_4,
   input  logic signed [ELEM_BITS-1:0]        req_vec_in_5,
   input  logic signed [ELEM_BITS-1:0]        req_vec_in_6,
   input  logic signed [ELEM_BITS-1:0]        req_vec_in_7,
   output logic                               rsp_strobe,
   output logic signed [e8bm_pkg::VEC_W-1:0]  rsp_vec_out_0,
   output logic signed [e8bm_pkg::VEC_W-1:0]  rsp_vec_out_1,
   output logic signed [e8bm_pkg::VEC_W-1:0]  rsp_vec_out_2,
   output logic signed [e8bm_pkg::VEC_W-1:0]  rsp_vec_out_3,
   output logic signed [e8bm_pkg::VEC_W-1:0]  rsp_vec_out_4,
   output logic signed [e8bm_pkg::VEC_W-1:0]  rsp_vec_out_5,
   output logic signed [e8bm_pkg::VEC_W-1:0]  rsp_vec_out_6,
   output logic signed [e8bm_pkg::VEC_W-1:0]  rsp_vec_out_7,
   output logic [e8bm_pkg::NORM_W-1:0]        rsp_square_norm,
   output logic                               rsp_valid_flag,
   output logic [e8bm_pkg::COSET_W-1:0]       rsp_coset_index
);

   localparam int NE  = e8bm_pkg::NUM_ELEMS;
   localparam int XW  = ELEM_BITS + 4;
   localparam int Q_W = ELEM_BITS + 2;
   localparam int VW  = e8bm_pkg::VEC_W;

   logic                      accept;

   // Stage 0: input register
   logic signed [ELEM_BITS-1:0]    vec_in   [NE];
   logic                           s0_vld_ff;
   logic                           s0_act_ff;
   logic [e8bm_pkg::TAU_W-1:0]     s0_tau_ff;
   logic signed [ELEM_BITS-1:0]    s0_vec_ff [NE];

   // Stage 1: forward map and inverse quotients
   logic signed [XW-1:0]           x_in     [NE];
   logic signed [Q_W-1:0]          q_in     [NE];
   logic                           div_ok_in;
   logic                           s1_vld_ff;
   logic                           s1_act_ff;
   logic [e8bm_pkg::TAU_W-1:0]     s1_tau_ff;
   logic signed [ELEM_BITS-1:0]    s1_vec_ff [NE];
   logic signed [XW-1:0]           s1_x_ff   [NE];
   logic signed [Q_W-1:0]          s1_q_ff   [NE];
   logic                           s1_div_ok_ff;

   // Stage 2: checks, output selection, squares
   e8bm_pkg::check_type            status;
   logic signed [XW-1:0]           norm_src  [NE];
   logic [e8bm_pkg::NORM_W-1:0]    norm_sum;
   logic signed [VW-1:0]           s2_vec_in [NE];
   logic                           s2_ok_in;
   logic [e8bm_pkg::COSET_W-1:0]   s2_coset_in;
   logic                           s2_vld_ff;
   logic signed [VW-1:0]           s2_vec_ff [NE];
   logic                           s2_ok_ff;
   logic [e8bm_pkg::COSET_W-1:0]   s2_coset_ff;

   // Stage 3: result register
   logic                           rsp_strobe_ff;
   logic signed [VW-1:0]           rsp_vec_ff [NE];
   logic [e8bm_pkg::NORM_W-1:0]    rsp_norm_ff;
   logic                           rsp_valid_ff;
   logic [e8bm_pkg::COSET_W-1:0]   rsp_coset_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   assign vec_in[0] = req_vec_in_0;
   assign vec_in[1] = req_vec_in_1;
   assign vec_in[2] = req_vec_in_2;
   assign vec_in[3] = req_vec_in_3;
   assign vec_in[4] = req_vec_in_4;
   assign vec_in[5] = req_vec_in_5;
   assign vec_in[6] = req_vec_in_6;
   assign vec_in[7] = req_vec_in_7;

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff     <= 1'b0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s0_vld_ff     <= accept;
         s1_vld_ff     <= s0_vld_ff;
         s2_vld_ff     <= s1_vld_ff;
         rsp_strobe_ff <= s2_vld_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (accept) begin
         s0_act_ff <= req_action;
         s0_tau_ff <= req_tau;
         s0_vec_ff <= vec_in;
      end
   end

   e8bm_fwd_map #(
      .IN_W (ELEM_BITS)
   ) u_fwd_map (
      .z (s0_vec_ff),
      .x (x_in)
   );

   e8bm_inv_solve #(
      .ELEM_BITS (ELEM_BITS)
   ) u_inv_solve (
      .v      (s0_vec_ff),
      .q      (q_in),
      .div_ok (div_ok_in)
   );

   always_ff @(posedge clock) begin
      s1_act_ff    <= s0_act_ff;
      s1_tau_ff    <= s0_tau_ff;
      s1_vec_ff    <= s0_vec_ff;
      s1_x_ff      <= x_in;
      s1_q_ff      <= q_in;
      s1_div_ok_ff <= div_ok_in;
   end

   e8bm_check #(
      .ELEM_BITS (ELEM_BITS)
   ) u_check (
      .q      (s1_q_ff),
      .v      (s1_vec_ff),
      .tau    (s1_tau_ff),
      .div_ok (s1_div_ok_ff),
      .status (status)
   );

   // Norm is taken over the P-side block: result when forward, input when inverse
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         if (s1_act_ff == e8bm_pkg::ACT_INVERSE) begin
            norm_src[k] = XW'(s1_vec_ff[k]);
         end else begin
            norm_src[k] = s1_x_ff[k];
         end
      end
   end

   e8bm_norm #(
      .XW (XW)
   ) u_norm (
      .clock (clock),
      .src   (norm_src),
      .sum   (norm_sum)
   );

   // Result selection; a failed inverse zeroes every field
   always_comb begin
      if (s1_act_ff == e8bm_pkg::ACT_INVERSE) begin
         s2_ok_in    = status.ok;
         s2_coset_in = status.ok ? status.syndrome : '0;
         for (int k = 0; k < NE; k++) begin
            s2_vec_in[k] = status.ok ? VW'(s1_q_ff[k]) : '0;
         end
      end else begin
         s2_ok_in    = 1'b1;
         s2_coset_in = '0;
         for (int k = 0; k < NE; k++) begin
            s2_vec_in[k] = VW'(s1_x_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_vec_ff   <= s2_vec_in;
      s2_ok_ff    <= s2_ok_in;
      s2_coset_ff <= s2_coset_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      rsp_vec_ff   <= s2_vec_ff;
      rsp_norm_ff  <= s2_ok_ff ? norm_sum : '0;
      rsp_valid_ff <= s2_ok_ff;
      rsp_coset_ff <= s2_coset_ff;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_vec_out_0   = rsp_vec_ff[0];
   assign rsp_vec_out_1   = rsp_vec_ff[1];
   assign rsp_vec_out_2   = rsp_vec_ff[2];
   assign rsp_vec_out_3   = rsp_vec_ff[3];
   assign rsp_vec_out_4   = rsp_vec_ff[4];
   assign rsp_vec_out_5   = rsp_vec_ff[5];
   assign rsp_vec_out_6   = rsp_vec_ff[6];
   assign rsp_vec_out_7   = rsp_vec_ff[7];
   assign rsp_square_norm = rsp_norm_ff;
   assign rsp_valid_flag  = rsp_valid_ff;
   assign rsp_coset_index = rsp_coset_ff;

   // Every accepted word gives exactly one strobe, after the input, map/solve, check/square and result registers
   a_strobe_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(accept, 4))
      else $error("result strobe not aligned with accepted word");

   // A failed inverse clears the norm and the coset index
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_flag) |-> (rsp_square_norm == '0 && rsp_coset_index == '0))
      else $error("failed inverse left nonzero fields");

   // A forward word always succeeds with a zero coset index
   a_forward_ok : assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_act_ff == e8bm_pkg::ACT_FORWARD) |-> ##2
      (rsp_strobe && rsp_valid_flag && rsp_coset_index == '0))
      else $error("forward word flagged invalid or with coset index");

endmodule
